// ===== sv/sdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// sdlp_pkg
// Shared types, constants and helpers of the serial detection line parser.
// ----------------------------------------------------------------------------
package sdlp_pkg;

	localparam int unsigned LINE_BYTES  = 64;
	localparam int unsigned LABEL_CHARS = 15;
	localparam int unsigned ADDR_W      = $clog2(LINE_BYTES);
	localparam int unsigned LAB_W       = $clog2(LABEL_CHARS + 1);

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [79:0] W_NO_WIFI = 80'("NO_WIFI");
	localparam logic [79:0] W_DET     = 80'("DET,");
	localparam logic [79:0] W_NONE    = 80'("NONE");
	// Service-offline frame word, ten ASCII characters.
	localparam logic [79:0] W_OFFLINE = 80'h41495F4F46464C494E45;
	localparam logic [79:0] W_READY   = 80'("READY");
	localparam int unsigned L_NO_WIFI = 7;
	localparam int unsigned L_DET     = 4;
	localparam int unsigned L_NONE    = 4;
	localparam int unsigned L_OFFLINE = 10;
	localparam int unsigned L_READY   = 5;

	typedef enum logic [2:0] {
		KIND_NO_WIFI = 3'd0,
		KIND_DET     = 3'd1,
		KIND_NONE    = 3'd2,
		KIND_OFFLINE = 3'd3,
		KIND_READY   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		CP_LEAD,
		CP_INT,
		CP_FRAC,
		CP_STOP
	} conf_state_t;

	typedef struct packed {
		logic clear;
		logic step;
	} conf_ctl_t;

	// True when character k of a right-aligned word equals ch.
	function automatic logic word_char_ok(input logic [79:0] word, input int unsigned wlen,
			input logic [ADDR_W-1:0] k, input logic [7:0] ch);
		logic ok;
		ok = 1'b0;
		if (int'(k) < int'(wlen))
			ok = (ch == word[8*(int'(wlen) - 1 - int'(k)) +: 8]);
		return ok;
	endfunction

endpackage

// ===== sv/sdlp_byte_if.sv =====
// ----------------------------------------------------------------------------
// sdlp_byte_if
// Valid/ready channel carrying one received serial byte per item.
// ----------------------------------------------------------------------------
interface sdlp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/sdlp_result_if.sv =====
// ----------------------------------------------------------------------------
// sdlp_result_if
// Valid/ready channel carrying one parsed frame result per item.
// ----------------------------------------------------------------------------
interface sdlp_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  frame_kind;
	logic [15:0] confidence_milli;
	logic [3:0]  label_length;
	logic [3:0]  char_index;
	logic [7:0]  label_char;
	logic        last;
	modport source (output valid, output frame_kind, output confidence_milli,
		output label_length, output char_index, output label_char, output last, input ready);
	modport sink (input valid, input frame_kind, input confidence_milli,
		input label_length, input char_index, input label_char, input last, output ready);
endinterface

// ===== sv/serial_detection_line_parser_unit.sv =====
// ----------------------------------------------------------------------------
// serial_detection_line_parser_unit
// Assembles serial bytes into lines and turns each line into frame results.
// ----------------------------------------------------------------------------
// One received byte is taken per item while the block is idle. A newline
// starts a walk over the stored line through the single read port of the line
// store, one character per cycle, after which the frame is decided in ST_FIN.
// A detection frame then reads each label character back from the store
// through ST_EMIT_RD and ST_EMIT_LD and holds each result on the output until
// the sink accepts it; the other frames give one result right after parsing.
// No new byte is accepted until the last result of a line has been taken.
// Carriage returns and non-printable bytes are dropped, and a line of more
// than LINE_BYTES - 1 printable characters is thrown away up to its newline.
module serial_detection_line_parser_unit (
	input  logic         clk,
	input  logic         arst_n,
	sdlp_byte_if.sink     rx,
	sdlp_result_if.source det
);
	import sdlp_pkg::*;

	state_t state_q, state_d;

	// Line assembly.
	logic [ADDR_W-1:0] wp_q;
	logic              discard_q;
	logic              rx_acc;
	logic              is_print;
	logic              mem_we;

	// Scan pipeline and frame recognition.
	logic [ADDR_W-1:0] len_q, rd_ptr_q, s_q, n_q, idx_q;
	logic              valid_s1;
	logic              started_q;
	logic              m_nw_q, m_det_q, m_none_q, m_off_q, m_rdy_q;
	logic [1:0]        comma_q;
	logic [LAB_W-1:0]  lab_q;
	logic              iss;
	logic [7:0]        rdata;
	logic [ADDR_W-1:0] raddr;
	logic              proc;
	logic [ADDR_W-1:0] li;

	// Result selection.
	logic              hit_nw, hit_det, hit_none, hit_off, hit_rdy, found;
	kind_t             kind_sel;
	logic [15:0]       milli, conf_q;
	conf_ctl_t         cctl;

	// Output register.
	logic              out_valid;
	kind_t             okind_q;
	logic [15:0]       oconf_q;
	logic [3:0]        olen_q, oidx_q;
	logic [7:0]        ochar_q;
	logic              olast_q;

	assign rx_acc   = rx.valid && rx.ready;
	assign is_print = (rx.rx_byte >= CH_SPACE) && (rx.rx_byte <= CH_TILDE);
	assign mem_we   = rx_acc && is_print && !discard_q && (wp_q != ADDR_W'(LINE_BYTES - 1));

	// Scan reads are issued the cycle before their data is checked; the emit phase reads label characters.
	assign iss   = (state_q == ST_SCAN) && (rd_ptr_q < len_q);
	assign raddr = (state_q == ST_SCAN) ? rd_ptr_q : ADDR_W'(s_q + ADDR_W'(4) + idx_q);

	sdlp_line_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wp_q),
		.wdata (rx.rx_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	// A character takes part in parsing once leading spaces are behind.
	assign proc = valid_s1 && (started_q || rdata != CH_SPACE);
	assign li   = ADDR_W'(n_q - ADDR_W'(4));

	assign cctl.clear = rx_acc && (rx.rx_byte == CH_LF);
	assign cctl.step  = proc && m_det_q && (n_q >= ADDR_W'(4)) && (comma_q == 2'd1)
		&& (rdata != CH_COMMA);

	sdlp_conf_parse u_conf (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cctl),
		.ch     (rdata),
		.milli  (milli)
	);

	// Line assembly and discard of overlong lines.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			discard_q <= 1'b0;
		end else if (rx_acc && rx.rx_byte != CH_CR) begin
			if (rx.rx_byte == CH_LF) begin
				wp_q      <= '0;
				discard_q <= 1'b0;
			end else if (!discard_q && is_print) begin
				if (wp_q != ADDR_W'(LINE_BYTES - 1)) begin
					wp_q <= wp_q + ADDR_W'(1);
				end else begin
					wp_q      <= '0;
					discard_q <= 1'b1;
				end
			end
		end
	end

	// Scan: each character is checked against every frame word at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			started_q <= 1'b0;
			rd_ptr_q  <= '0;
			len_q     <= '0;
			n_q       <= '0;
			s_q       <= '0;
			comma_q   <= '0;
			lab_q     <= '0;
			m_nw_q    <= 1'b0;
			m_det_q   <= 1'b0;
			m_none_q  <= 1'b0;
			m_off_q   <= 1'b0;
			m_rdy_q   <= 1'b0;
		end else if (state_q == ST_IDLE) begin
			valid_s1  <= 1'b0;
			started_q <= 1'b0;
			rd_ptr_q  <= '0;
			len_q     <= wp_q;
			n_q       <= '0;
			comma_q   <= '0;
			lab_q     <= '0;
			m_nw_q    <= 1'b1;
			m_det_q   <= 1'b1;
			m_none_q  <= 1'b1;
			m_off_q   <= 1'b1;
			m_rdy_q   <= 1'b1;
		end else if (state_q == ST_SCAN) begin
			valid_s1 <= iss;
			if (iss)
				rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
			if (proc) begin
				if (!started_q) begin
					started_q <= 1'b1;
					s_q       <= ADDR_W'(rd_ptr_q - ADDR_W'(1));
				end
				n_q      <= n_q + ADDR_W'(1);
				m_nw_q   <= m_nw_q && word_char_ok(W_NO_WIFI, L_NO_WIFI, n_q, rdata);
				m_none_q <= m_none_q && word_char_ok(W_NONE, L_NONE, n_q, rdata);
				m_off_q  <= m_off_q && word_char_ok(W_OFFLINE, L_OFFLINE, n_q, rdata);
				m_rdy_q  <= m_rdy_q && word_char_ok(W_READY, L_READY, n_q, rdata);
				if (n_q < ADDR_W'(4)) begin
					m_det_q <= m_det_q && word_char_ok(W_DET, L_DET, n_q, rdata);
				end else if (m_det_q) begin
					if (rdata == CH_COMMA) begin
						if (comma_q != 2'd2)
							comma_q <= comma_q + 2'd1;
					end else if (comma_q == 2'd0 && li < ADDR_W'(LABEL_CHARS)
							&& rdata != CH_SPACE) begin
						// Trailing blanks are trimmed by remembering the last non-blank.
						lab_q <= LAB_W'(li + ADDR_W'(1));
					end
				end
			end
		end
	end

	// Frame decision once the whole line has been seen.
	always_comb begin
		hit_nw   = m_nw_q && (n_q == ADDR_W'(L_NO_WIFI));
		hit_det  = m_det_q && (n_q >= ADDR_W'(L_DET));
		hit_none = m_none_q && (n_q == ADDR_W'(L_NONE));
		hit_off  = m_off_q && (n_q == ADDR_W'(L_OFFLINE));
		hit_rdy  = m_rdy_q && (n_q == ADDR_W'(L_READY));
		found    = 1'b1;
		kind_sel = KIND_NO_WIFI;
		if (hit_nw)
			kind_sel = KIND_NO_WIFI;
		else if (hit_det) begin
			kind_sel = KIND_DET;
			found    = (comma_q == 2'd1) && (lab_q != '0);
		end else if (hit_none)
			kind_sel = KIND_NONE;
		else if (hit_off)
			kind_sel = KIND_OFFLINE;
		else if (hit_rdy)
			kind_sel = KIND_READY;
		else
			found = 1'b0;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (rx_acc && rx.rx_byte == CH_LF && !discard_q)
					state_d = ST_SCAN;
			ST_SCAN:
				if (!iss && !valid_s1)
					state_d = ST_FIN;
			ST_FIN:
				if (!found)
					state_d = ST_IDLE;
				else if (kind_sel == KIND_DET)
					state_d = ST_EMIT_RD;
				else
					state_d = ST_OUT;
			ST_EMIT_RD: state_d = ST_EMIT_LD;
			ST_EMIT_LD: state_d = ST_OUT;
			ST_OUT:
				if (det.ready)
					state_d = olast_q ? ST_IDLE : ST_EMIT_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Handshake outputs.
	always_comb begin
		rx.ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
	end

	// Result register and label walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (state_q == ST_FIN)
			idx_q <= '0;
		else if (state_q == ST_OUT && det.ready && !olast_q)
			idx_q <= idx_q + ADDR_W'(1);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			conf_q  <= milli;
			okind_q <= kind_sel;
			oconf_q <= '0;
			olen_q  <= '0;
			oidx_q  <= '0;
			ochar_q <= '0;
			olast_q <= 1'b1;
		end else if (state_q == ST_EMIT_LD) begin
			okind_q <= KIND_DET;
			oconf_q <= conf_q;
			olen_q  <= 4'(lab_q);
			oidx_q  <= 4'(idx_q);
			ochar_q <= rdata;
			olast_q <= (idx_q + ADDR_W'(1)) == ADDR_W'(lab_q);
		end
	end

	assign det.valid            = out_valid;
	assign det.frame_kind       = okind_q;
	assign det.confidence_milli = oconf_q;
	assign det.label_length     = olen_q;
	assign det.char_index       = oidx_q;
	assign det.label_char       = ochar_q;
	assign det.last             = olast_q;

	// The block never takes a byte while a result is pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rx.ready && det.valid)) else $error("byte accepted while result pending");

	// Frames other than detections give a single result.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		det.valid && det.frame_kind != KIND_DET |-> det.last)
		else $error("non-detection frame without last");

	// Detection results walk the label within its length.
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		det.valid && det.frame_kind == KIND_DET |-> det.char_index < det.label_length)
		else $error("label index beyond label length");

	// After a non-final result is taken, the next one follows the same frame.
	a_resume: assert property (@(posedge clk) disable iff (!arst_n)
		det.valid && det.ready && !det.last |=> !rx.ready)
		else $error("frame ended before its last result");
endmodule

// ===== sv/sdlp_line_ram.sv =====
// ----------------------------------------------------------------------------
// sdlp_line_ram
// Line store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sdlp_line_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [sdlp_pkg::ADDR_W-1:0] waddr,
	input  logic [7:0]                 wdata,
	input  logic [sdlp_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                 rdata
);
	import sdlp_pkg::*;

	logic [7:0] mem [LINE_BYTES];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/sdlp_conf_parse.sv =====
// ----------------------------------------------------------------------------
// sdlp_conf_parse
// Character-serial decimal parser for the confidence field, in thousandths.
// ----------------------------------------------------------------------------
module sdlp_conf_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sdlp_pkg::conf_ctl_t  ctl,
	input  logic [7:0]           ch,
	output logic [15:0]          milli
);
	import sdlp_pkg::*;

	conf_state_t cst_q;
	logic        neg_q;
	logic [6:0]  whole_q;
	logic [9:0]  frac_q;
	logic [1:0]  fd_q;
	logic        is_digit;
	logic [3:0]  dig;
	logic [10:0] whole_n;
	logic [9:0]  frac_sc;
	logic [16:0] sum;

	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign dig      = 4'(ch - CH_ZERO);
	// Any whole part of 66 or more saturates, so clamping at 100 loses nothing.
	assign whole_n  = 11'(whole_q) * 11'd10 + 11'(dig);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q   <= CP_LEAD;
			neg_q   <= 1'b0;
			whole_q <= '0;
			frac_q  <= '0;
			fd_q    <= '0;
		end else if (ctl.clear) begin
			cst_q   <= CP_LEAD;
			neg_q   <= 1'b0;
			whole_q <= '0;
			frac_q  <= '0;
			fd_q    <= '0;
		end else if (ctl.step) begin
			case (cst_q)
				CP_LEAD: begin
					if (ch == CH_SPACE) begin
						cst_q <= CP_LEAD;
					end else if (ch == CH_PLUS || ch == CH_MINUS) begin
						neg_q <= (ch == CH_MINUS);
						cst_q <= CP_INT;
					end else if (is_digit) begin
						whole_q <= 7'(dig);
						cst_q   <= CP_INT;
					end else if (ch == CH_DOT) begin
						cst_q <= CP_FRAC;
					end else begin
						cst_q <= CP_STOP;
					end
				end
				CP_INT: begin
					if (is_digit)
						whole_q <= (whole_n > 11'd100) ? 7'd100 : 7'(whole_n);
					else if (ch == CH_DOT)
						cst_q <= CP_FRAC;
					else
						cst_q <= CP_STOP;
				end
				CP_FRAC: begin
					if (is_digit) begin
						if (fd_q != 2'd3) begin
							frac_q <= 10'(frac_q * 10'd10 + 10'(dig));
							fd_q   <= fd_q + 2'd1;
						end
					end else begin
						cst_q <= CP_STOP;
					end
				end
				default: cst_q <= CP_STOP;
			endcase
		end
	end

	always_comb begin
		case (fd_q)
			2'd1:    frac_sc = 10'(frac_q * 10'd100);
			2'd2:    frac_sc = 10'(frac_q * 10'd10);
			2'd3:    frac_sc = frac_q;
			default: frac_sc = '0;
		endcase
		sum = 17'(whole_q) * 17'd1000 + 17'(frac_sc);
		if (neg_q)
			milli = '0;
		else if (sum > 17'd65535)
			milli = 16'hFFFF;
		else
			milli = 16'(sum);
	end
endmodule
